// ===== rtl/tpf_pkg.sv =====
// Shared constants and types for the tabulated pair force block.
package tpf_pkg;

	localparam int TableDepthDefault = 1024;
	localparam int RegW = 31;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 31;

	localparam logic [CfgIdxW-1:0] CFG_RADIUS_MIN = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_RADIUS_MAX = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_INDEX_SCALE = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_INV_SPACING = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_TABLE_LEN = 3'd4;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_PAIR = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic signed [47:0] E_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] E_MIN = 48'sh8000_0000_0000;

	typedef struct packed {
		logic [1:0] mode;
		logic [9:0] table_index;
		logic signed [31:0] table_value;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
	} tpf_in_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic signed [31:0] pair_potential;
		logic signed [47:0] energy_total;
		logic in_range;
	} tpf_out_t;

	// Unsigned-magnitude to signed 32-bit with saturation.
	function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] m);
		logic signed [31:0] r;
		if (neg) begin
			if (m >= 64'h8000_0000) r = 32'sh8000_0000;
			else r = -($signed(m[31:0]));
		end else begin
			if (m > 64'h7FFF_FFFF) r = 32'sh7FFF_FFFF;
			else r = $signed(m[31:0]);
		end
		return r;
	endfunction

endpackage

// ===== rtl/tpf_stream_if.sv =====
// Valid/ready channel carrying one payload type.
interface tpf_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/tpf_ram.sv =====
// Generic single-port RAM with registered read.
module tpf_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== rtl/tpf_divsqrt.sv =====
// Shared iterative unit: bit-serial square root or restoring divide.
module tpf_divsqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic is_sqrt,
	input logic [63:0] num,
	input logic [31:0] den,
	output logic busy,
	output logic [63:0] result
);
	logic [63:0] rem_q;
	logic [63:0] x_q;
	logic [63:0] quo_q;
	logic [31:0] den_q;
	logic sq_q;
	logic [6:0] cnt_q;
	logic [64:0] trial;
	logic [63:0] rem_sh;
	logic [65:0] sq_rem;
	logic [65:0] sq_trial;

	assign busy = (cnt_q != 7'd0);
	assign result = quo_q;
	assign rem_sh = {rem_q[62:0], x_q[63]};
	assign trial = {1'b0, rem_sh} - {33'd0, den_q};
	assign sq_rem = {rem_q, x_q[63:62]};
	assign sq_trial = sq_rem - {quo_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= is_sqrt ? 7'd32 : 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			x_q <= num;
			quo_q <= '0;
			den_q <= den;
			sq_q <= is_sqrt;
		end else if (busy) begin
			if (sq_q) begin
				x_q <= {x_q[61:0], 2'b00};
				if (!sq_trial[65]) begin
					rem_q <= sq_trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= sq_rem[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end else begin
				x_q <= {x_q[62:0], 1'b0};
				if (!trial[64]) begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
		end
	end
endmodule

// ===== rtl/tabulated_pair_force.sv =====
// Top level of the tabulated pair force block.
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   tpf_in_t
//   out_ch   out  valid/ready   tpf_out_t
//   cfg      in   we only       index, data
// An in-range pair is loaded, its axis differences are squared and summed, and
// the sum goes through the root; index and table reads follow, then a multiply
// and divide per axis, and the result is registered before it is offered.
// A pair out of range skips the table and the divides; writes, clears and idle modes skip all the arithmetic.
// Reset sets the state to idle, clears the energy sum and loads the config defaults; the table stays undefined.
// The input is not ready while an item is in work or its result waits.
module tabulated_pair_force
	import tpf_pkg::*;
#(
	parameter int TABLE_DEPTH = TableDepthDefault
) (
	input logic clk,
	input logic arst_n,
	tpf_stream_if.sink in_ch,
	tpf_stream_if.source out_ch,
	input logic cfg_we,
	input logic [CfgIdxW-1:0] cfg_index,
	input logic [CfgDataW-1:0] cfg_data
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int LW = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIFF = 4'd1;
	localparam logic [3:0] S_SQ = 4'd2;
	localparam logic [3:0] S_SQRT = 4'd3;
	localparam logic [3:0] S_IDX = 4'd4;
	localparam logic [3:0] S_RD0 = 4'd5;
	localparam logic [3:0] S_RD1 = 4'd6;
	localparam logic [3:0] S_SLOPE = 4'd7;
	localparam logic [3:0] S_DIV = 4'd8;
	localparam logic [3:0] S_DIVW = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;
	localparam logic [3:0] S_OUT = 4'd11;
	localparam logic [3:0] S_MUL = 4'd12;

	logic [3:0] state_q;
	logic [30:0] rmin_q, rmax_q, iscale_q, ispace_q;
	logic [10:0] tlen_q;
	logic signed [47:0] energy_q;
	tpf_in_t in_q;
	tpf_out_t out_q;
	logic [32:0] dmag_q [3];
	logic dneg_q [3];
	logic [63:0] sum_q;
	logic [1:0] ax_q;
	logic [31:0] r_q;
	logic [AW-1:0] p_q;
	logic last_q;
	logic signed [31:0] v0_q;
	logic signed [31:0] slope_q;
	logic [63:0] prod_q;
	logic signed [31:0] f_q [3];
	logic inr_q;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0] ram_rdata;
	logic du_start, du_sqrt, du_busy;
	logic [63:0] du_num, du_res;
	logic [LW-1:0] len_eff;
	logic [61:0] idx_prod;
	logic [30:0] idx_hi;
	logic signed [32:0] vdiff;
	logic [32:0] vdiff_mag;
	logic [63:0] smag_prod;
	logic [31:0] smag;
	logic signed [32:0] dsub [3];
	logic signed [48:0] e_add;

	tpf_ram #(.Width(32), .Depth(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_q.table_value),
		.rdata(ram_rdata)
	);

	tpf_divsqrt u_du (
		.clk(clk), .arst_n(arst_n), .start(du_start), .is_sqrt(du_sqrt),
		.num(du_num), .den(r_q), .busy(du_busy), .result(du_res)
	);

	always_comb begin
		if (tlen_q < 11'd2) len_eff = LW'(2);
		else if ({21'd0, tlen_q} > 32'(TABLE_DEPTH)) len_eff = LW'(TABLE_DEPTH);
		else len_eff = LW'(tlen_q);
	end

	assign dsub[0] = $signed({in_q.second_x[31], in_q.second_x})
		- $signed({in_q.first_x[31], in_q.first_x});
	assign dsub[1] = $signed({in_q.second_y[31], in_q.second_y})
		- $signed({in_q.first_y[31], in_q.first_y});
	assign dsub[2] = $signed({in_q.second_z[31], in_q.second_z})
		- $signed({in_q.first_z[31], in_q.first_z});

	assign idx_prod = 62'(r_q[30:0] - rmin_q) * 62'(iscale_q);
	assign idx_hi = idx_prod[61:31] >> 1;
	assign vdiff = $signed({ram_rdata[31], ram_rdata}) - $signed({v0_q[31], v0_q});
	assign vdiff_mag = vdiff[32] ? 33'(-vdiff) : 33'(vdiff);
	assign smag_prod = 64'(vdiff_mag) * 64'(ispace_q);
	assign smag = slope_q[31] ? 32'(-slope_q) : 32'(slope_q);
	assign e_add = {energy_q[47], energy_q} + 49'(v0_q);

	assign ram_we = (state_q == S_DIFF) && (in_q.mode == MODE_WRITE)
		&& ({22'd0, in_q.table_index} < 32'(TABLE_DEPTH));
	assign ram_addr = (state_q == S_DIFF) ? AW'(in_q.table_index) : p_q
		+ ((state_q == S_RD1) && !last_q ? AW'(1) : AW'(0));
	assign du_start = ((state_q == S_SQ) && ax_q == 2'd3)
		|| (state_q == S_DIV);
	assign du_sqrt = (state_q == S_SQ);
	assign du_num = (state_q == S_SQ) ? sum_q : prod_q;

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmin_q <= '0;
			rmax_q <= 31'd1310720;
			iscale_q <= 31'd65536;
			ispace_q <= 31'd65536;
			tlen_q <= 11'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RADIUS_MIN: rmin_q <= cfg_data;
				CFG_RADIUS_MAX: rmax_q <= cfg_data;
				CFG_INDEX_SCALE: iscale_q <= cfg_data;
				CFG_INV_SPACING: ispace_q <= cfg_data;
				CFG_TABLE_LEN: tlen_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			energy_q <= '0;
			ax_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_ch.valid) state_q <= S_DIFF;
				S_DIFF: begin
					ax_q <= '0;
					if (in_q.mode == MODE_PAIR) state_q <= S_SQ;
					else begin
						if (in_q.mode == MODE_CLEAR) energy_q <= '0;
						state_q <= S_DONE;
					end
				end
				S_SQ: begin
					if (dmag_q[0][32] || dmag_q[1][32] || dmag_q[2][32]
						|| dmag_q[0][31] || dmag_q[1][31] || dmag_q[2][31])
						state_q <= S_DONE;
					else if (ax_q == 2'd3) state_q <= S_SQRT;
					else ax_q <= ax_q + 2'd1;
				end
				S_SQRT: if (!du_busy) state_q <= S_IDX;
				S_IDX: begin
					if (r_q > {1'b0, rmin_q} && r_q < {1'b0, rmax_q}) state_q <= S_RD0;
					else state_q <= S_DONE;
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_SLOPE;
				S_SLOPE: begin
					ax_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: state_q <= S_DIVW;
				S_DIVW: begin
					if (!du_busy) begin
						if (ax_q == 2'd2) begin
							if (e_add > 49'(E_MAX)) energy_q <= E_MAX;
							else if (e_add < 49'(E_MIN)) energy_q <= E_MIN;
							else energy_q <= e_add[47:0];
							state_q <= S_DONE;
						end else begin
							ax_q <= ax_q + 2'd1;
							state_q <= S_MUL;
						end
					end
				end
				S_DONE: state_q <= S_OUT;
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				in_q <= in_ch.payload;
				inr_q <= 1'b0;
				v0_q <= '0;
				f_q[0] <= '0;
				f_q[1] <= '0;
				f_q[2] <= '0;
			end
			S_DIFF: begin
				sum_q <= '0;
				for (int i = 0; i < 3; i++) begin
					dneg_q[i] <= dsub[i][32];
					dmag_q[i] <= dsub[i][32] ? 33'(-dsub[i]) : 33'(dsub[i]);
				end
			end
			S_SQ: if (ax_q != 2'd3) sum_q <= sum_q + 64'(dmag_q[ax_q][30:0]) * 64'(dmag_q[ax_q][30:0]);
			S_SQRT: r_q <= du_res[31:0];
			S_IDX: begin
				if (idx_prod[61:32] >= 30'(len_eff - LW'(1))) begin
					p_q <= AW'(len_eff - LW'(1));
					last_q <= 1'b1;
				end else begin
					p_q <= AW'(idx_hi);
					last_q <= (idx_prod[61:32] == 30'(len_eff - LW'(1)));
				end
			end
			S_RD0: ;
			S_RD1: v0_q <= ram_rdata;
			S_SLOPE: inr_q <= 1'b1;
			S_DIV: ;
			S_DIVW: ;
			default: ;
		endcase
		if (state_q == S_SLOPE) begin
			if (last_q) slope_q <= '0;
			else slope_q <= sat32(vdiff[32] ? 1'b1 : 1'b0, smag_prod >> 16);
		end
		if (state_q == S_DIVW && !du_busy)
			f_q[ax_q] <= sat32(slope_q[31] != dneg_q[ax_q] && smag != 0
				&& dmag_q[ax_q] != 0, du_res);
		if (state_q == S_DONE) begin
			out_q.force_x <= f_q[0];
			out_q.force_y <= f_q[1];
			out_q.force_z <= f_q[2];
			out_q.pair_potential <= v0_q;
			out_q.energy_total <= energy_q;
			out_q.in_range <= inr_q;
		end
	end

	// Product for the divide: slope magnitude times axis magnitude.
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) prod_q <= 64'(smag) * 64'(dmag_q[ax_q][30:0]);
	end

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(state_q) == S_DONE) else $error("bad output entry");
	a_du_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !du_busy) else $error("unit busy at output");
`endif
endmodule
